// ===== src/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the CI-V frame and frequency decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int CNT_W         = 9;
	localparam int FREQ_W        = 54;
	localparam int POW_W         = 47;
	localparam int OUT_W         = 112;
	localparam int MAX_BCD_BYTES = 8;
	localparam int HDR_BYTES     = 5;   // preamble, addresses and command
	localparam int MIN_FRAME     = 6;

	localparam logic [7:0]       PREAMBLE   = 8'hFE;
	localparam logic [7:0]       TERMINATOR = 8'hFD;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;

	// configuration register indexes
	localparam logic [1:0] REG_CMD_READ_FREQ = 2'd0;
	localparam logic [1:0] REG_CMD_SET_FREQ  = 2'd1;
	localparam logic [1:0] REG_CMD_READ_MODE = 2'd2;
	localparam logic [1:0] REG_CMD_SET_MODE  = 2'd3;

	// weight of each packed bcd pair, little-endian
	localparam logic [POW_W-1:0] POW100 [MAX_BCD_BYTES] = '{
		47'd1,
		47'd100,
		47'd10000,
		47'd1000000,
		47'd100000000,
		47'd10000000000,
		47'd1000000000000,
		47'd100000000000000
	};

	typedef struct packed {
		logic              dec;
		logic [FREQ_W-1:0] term;
	} bcd_term_t;

endpackage

// ===== src/cfd_bcd_term.sv =====
// ----------------------------------------------------------------------------
// cfd_bcd_term
// Weighted value of one packed bcd payload byte and its decimal check.
// ----------------------------------------------------------------------------
module cfd_bcd_term
	import cfd_pkg::*;
(
	input  logic [7:0]       rx_byte,
	input  logic [CNT_W-1:0] count,
	output bcd_term_t        result
);

	logic [3:0]       hi;
	logic [3:0]       lo;
	logic [6:0]       pair;
	logic [CNT_W-1:0] rel;
	logic [2:0]       pos;
	logic             in_range;
	logic [POW_W-1:0] weight;

	assign hi   = rx_byte[7:4];
	assign lo   = rx_byte[3:0];
	assign pair = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
	assign rel  = count - CNT_W'(HDR_BYTES);
	assign pos  = rel[2:0];

	assign in_range = (count >= CNT_W'(HDR_BYTES)) &&
		(count < CNT_W'(HDR_BYTES + MAX_BCD_BYTES));
	assign weight   = POW100[pos];

	assign result.dec  = (hi <= 4'd9) && (lo <= 4'd9);
	assign result.term = (in_range && result.dec) ?
		(FREQ_W'(pair) * FREQ_W'(weight)) : '0;

endmodule

// ===== src/civ_frame_and_frequency_decoder.sv =====
// ----------------------------------------------------------------------------
// civ_frame_and_frequency_decoder
// Parses a received CI-V buffer byte by byte and reports frame, frequency and
// mode on the final byte.
// ----------------------------------------------------------------------------
// output: a final byte passes through the input register, and its result then waits in the result register
// throughput: one byte per cycle; input stalls only while a result waits
// the bcd multiply of each byte is registered and summed on the next byte
// reset: asynchronous, active low; command registers return to 3, 5, 4, 6
module civ_frame_and_frequency_decoder
	import cfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // rx_byte
	input  logic             s_axis_tlast,   // end_of_buffer
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// frame_ok, dest_addr, src_addr, command, payload_len, freq_ok, freq_hz,
	// mode_ok, mode_code, filter_code, has_filter, zero pad
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_wdata
);

	logic [7:0] cmd_read_freq_q;
	logic [7:0] cmd_set_freq_q;
	logic [7:0] cmd_read_mode_q;
	logic [7:0] cmd_set_mode_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [CNT_W-1:0]  count_q;
	logic              preamble_q;
	logic              header_q;
	logic              digits_q;
	logic [7:0]        dest_q;
	logic [7:0]        src_q;
	logic [7:0]        cmd_q;
	logic [7:0]        first_q;
	logic [7:0]        second_q;
	logic [FREQ_W-1:0] accum_q;
	bcd_term_t         held_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	bcd_term_t         cur_term;
	logic              out_free;
	logic              go;
	logic              preamble_n;
	logic              header_n;
	logic              digits_n;
	logic [7:0]        dest_n;
	logic [7:0]        src_n;
	logic [7:0]        cmd_n;
	logic [FREQ_W-1:0] accum_n;
	logic [CNT_W-1:0]  count_n;
	logic [CNT_W-1:0]  plen;
	logic [7:0]        plen_sat;
	logic              frame_ok;
	logic              freq_ok;
	logic              mode_ok;
	logic              has_filter;
	logic [OUT_W-1:0]  result;

	cfd_bcd_term u_term (
		.rx_byte (byte_s1),
		.count   (count_q),
		.result  (cur_term)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign go            = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_read_freq_q <= 8'd3;
			cmd_set_freq_q  <= 8'd5;
			cmd_read_mode_q <= 8'd4;
			cmd_set_mode_q  <= 8'd6;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMD_READ_FREQ: cmd_read_freq_q <= cfg_wdata;
				REG_CMD_SET_FREQ:  cmd_set_freq_q  <= cfg_wdata;
				REG_CMD_READ_MODE: cmd_read_mode_q <= cfg_wdata;
				REG_CMD_SET_MODE:  cmd_set_mode_q  <= cfg_wdata;
				default:           cmd_read_freq_q <= cmd_read_freq_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		preamble_n = preamble_q && !((count_q < CNT_W'(2)) && (byte_s1 != PREAMBLE));
		header_n   = header_q && !(((count_q == CNT_W'(2)) || (count_q == CNT_W'(3))) &&
			(byte_s1 == TERMINATOR));
		dest_n     = (count_q == CNT_W'(2)) ? byte_s1 : dest_q;
		src_n      = (count_q == CNT_W'(3)) ? byte_s1 : src_q;
		cmd_n      = (count_q == CNT_W'(4)) ? byte_s1 : cmd_q;
		// the held byte becomes payload once a further byte follows it
		digits_n   = digits_q && ((count_q <= CNT_W'(HDR_BYTES)) || held_q.dec);
		accum_n    = accum_q + held_q.term;
		count_n    = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);

		plen     = count_q - CNT_W'(HDR_BYTES);
		plen_sat = (plen > CNT_W'(255)) ? 8'hFF : plen[7:0];
		frame_ok = (count_q >= CNT_W'(MIN_FRAME - 1)) && preamble_n && header_n &&
			(byte_s1 == TERMINATOR);
		freq_ok  = frame_ok && ((cmd_n == cmd_read_freq_q) || (cmd_n == cmd_set_freq_q)) &&
			(plen >= CNT_W'(1)) && (plen <= CNT_W'(MAX_BCD_BYTES)) && digits_n;
		mode_ok  = frame_ok && ((cmd_n == cmd_read_mode_q) || (cmd_n == cmd_set_mode_q)) &&
			(plen >= CNT_W'(1));
		has_filter = mode_ok && (plen >= CNT_W'(2));

		result = {
			6'b0,
			has_filter,
			has_filter ? second_q : 8'h00,
			mode_ok ? first_q : 8'h00,
			mode_ok,
			freq_ok ? accum_n : {FREQ_W{1'b0}},
			freq_ok,
			frame_ok ? plen_sat : 8'h00,
			frame_ok ? cmd_n : 8'h00,
			frame_ok ? src_n : 8'h00,
			frame_ok ? dest_n : 8'h00,
			frame_ok
		};
	end

	// per-buffer state, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			preamble_q <= 1'b1;
			header_q   <= 1'b1;
			digits_q   <= 1'b1;
			dest_q     <= '0;
			src_q      <= '0;
			cmd_q      <= '0;
			first_q    <= '0;
			second_q   <= '0;
			accum_q    <= '0;
			held_q     <= '0;
		end else if (go) begin
			if (last_s1) begin
				count_q    <= '0;
				preamble_q <= 1'b1;
				header_q   <= 1'b1;
				digits_q   <= 1'b1;
				dest_q     <= '0;
				src_q      <= '0;
				cmd_q      <= '0;
				first_q    <= '0;
				second_q   <= '0;
				accum_q    <= '0;
				held_q     <= '0;
			end else begin
				count_q    <= count_n;
				preamble_q <= preamble_n;
				header_q   <= header_n;
				digits_q   <= digits_n;
				dest_q     <= dest_n;
				src_q      <= src_n;
				cmd_q      <= cmd_n;
				accum_q    <= accum_n;
				held_q     <= cur_term;
				if (count_q == CNT_W'(HDR_BYTES)) begin
					first_q <= byte_s1;
				end
				if (count_q == CNT_W'(HDR_BYTES + 1)) begin
					second_q <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			out_data_q <= result;
		end
	end

endmodule
